/* hw/rtl/nsps_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nsps_pkg
// Shared widths, command and register codes, the cordic angle table and the
// cordic request struct.
// ----------------------------------------------------------------------------
package nsps_pkg;

  // coordinate width of every point field
  localparam int COORD_BITS = 32;

  // input commands
  localparam logic [1:0] CMD_CLEAR = 2'd0;
  localparam logic [1:0] CMD_LOAD  = 2'd1;
  localparam logic [1:0] CMD_QUERY = 2'd2;

  // configuration register indexes
  localparam logic [2:0] REG_RADIUS  = 3'd0;
  localparam logic [2:0] REG_USE_MAP = 3'd1;
  localparam logic [2:0] REG_OFFSET  = 3'd2;
  localparam logic [2:0] REG_FLATTEN = 3'd3;
  localparam logic [2:0] REG_GROUND  = 3'd4;

  // cordic datapath
  localparam int CORDIC_STEPS = 30;
  localparam int STEP_W       = 5;
  localparam int XW           = 44;  // x, y of the cordic
  localparam int ZW           = 34;  // angle accumulator

  // shared multiplier
  localparam int MW = 35;            // signed operand width
  localparam int PW = 71;            // signed product width

  typedef struct packed {
    logic start;
    logic vec;                       // 1 vectoring, 0 rotation
  } cordic_req_t;

  // atan(2^-i) with 2^31 = pi
  function automatic logic [31:0] atan_val(input logic [STEP_W-1:0] i);
    logic [31:0] v;
    case (i)
      5'd0:  v = 32'd536870912;
      5'd1:  v = 32'd316933406;
      5'd2:  v = 32'd167458907;
      5'd3:  v = 32'd85004756;
      5'd4:  v = 32'd42667331;
      5'd5:  v = 32'd21354465;
      5'd6:  v = 32'd10679838;
      5'd7:  v = 32'd5340245;
      5'd8:  v = 32'd2670163;
      5'd9:  v = 32'd1335087;
      5'd10: v = 32'd667544;
      5'd11: v = 32'd333772;
      5'd12: v = 32'd166886;
      5'd13: v = 32'd83443;
      5'd14: v = 32'd41722;
      5'd15: v = 32'd20861;
      5'd16: v = 32'd10430;
      5'd17: v = 32'd5215;
      5'd18: v = 32'd2608;
      5'd19: v = 32'd1304;
      5'd20: v = 32'd652;
      5'd21: v = 32'd326;
      5'd22: v = 32'd163;
      5'd23: v = 32'd81;
      5'd24: v = 32'd41;
      5'd25: v = 32'd20;
      5'd26: v = 32'd10;
      5'd27: v = 32'd5;
      5'd28: v = 32'd3;
      5'd29: v = 32'd1;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

/* hw/rtl/nsps_mul.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nsps_mul
// Iterative signed multiplier, eight bits of the second operand per cycle.
// ----------------------------------------------------------------------------
module nsps_mul
  import nsps_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  input  wire logic signed [MW-1:0] a,
  input  wire logic signed [MW-1:0] b,
  output logic                      done,
  output logic signed [PW-1:0]      p
);

  localparam int DIG_W = 8;
  localparam int DIG_N = (MW + DIG_W - 1) / DIG_W;
  localparam int MBW   = DIG_N * DIG_W;
  localparam int AW2   = 2 * MW;

  typedef enum logic [1:0] {M_IDLE, M_RUN, M_FIX} mstate_t;

  mstate_t              state_r;
  logic [2:0]           cnt_r;
  logic [MW-1:0]        ma_r;
  logic [MBW-1:0]       mb_r;
  logic                 neg_r;
  logic [AW2-1:0]       acc_r;
  logic [AW2-1:0]       acc_nxt;
  logic [MW+DIG_W-1:0]  pp;
  logic                 done_r;
  logic signed [PW-1:0] p_r;
  logic [MW-1:0]        abs_a;
  logic [MW-1:0]        abs_b;

  always_comb begin
    abs_a   = a[MW-1] ? MW'(-a) : MW'(a);
    abs_b   = b[MW-1] ? MW'(-b) : MW'(b);
    pp      = ma_r * mb_r[MBW-1 -: DIG_W];
    acc_nxt = (acc_r << DIG_W) + AW2'(pp);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= M_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      case (state_r)
        M_IDLE: begin
          if (start) begin
            ma_r    <= abs_a;
            mb_r    <= MBW'(abs_b);
            neg_r   <= a[MW-1] ^ b[MW-1];
            acc_r   <= '0;
            cnt_r   <= '0;
            state_r <= M_RUN;
          end
        end
        M_RUN: begin
          acc_r <= acc_nxt;
          mb_r  <= mb_r << DIG_W;
          cnt_r <= cnt_r + 3'd1;
          if (cnt_r == 3'(DIG_N - 1)) begin
            state_r <= M_FIX;
          end
        end
        M_FIX: begin
          p_r     <= neg_r ? -$signed({1'b0, acc_r}) : $signed({1'b0, acc_r});
          done_r  <= 1'b1;
          state_r <= M_IDLE;
        end
        default: state_r <= M_IDLE;
      endcase
    end
  end

  assign done = done_r;
  assign p    = p_r;

endmodule
`default_nettype wire

/* hw/rtl/nsps_cordic.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nsps_cordic
// Shared cordic: vectoring with pre-normalization, or rotation, 30 steps.
// ----------------------------------------------------------------------------
module nsps_cordic
  import nsps_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire cordic_req_t          req,
  input  wire logic signed [XW-1:0] x_in,
  input  wire logic signed [XW-1:0] y_in,
  input  wire logic signed [ZW-1:0] z_in,
  output logic                      done,
  output logic signed [XW-1:0]      x_out,
  output logic signed [XW-1:0]      y_out,
  output logic signed [ZW-1:0]      z_out
);

  typedef enum logic [1:0] {C_IDLE, C_NORM, C_ITER} cstate_t;

  localparam logic signed [XW-1:0] NORM_LIM = XW'(64'sd1 <<< 40);
  localparam logic signed [ZW-1:0] Z_PI     = ZW'(64'sd2147483648);

  cstate_t              state_r;
  logic                 vec_r;
  logic [STEP_W-1:0]    step_r;
  logic signed [XW-1:0] x_r, y_r;
  logic signed [ZW-1:0] z_r;
  logic                 done_r;

  logic signed [XW-1:0] xs, ys, ax, ay;
  logic signed [XW-1:0] x_nxt, y_nxt;
  logic signed [ZW-1:0] z_nxt, at;
  logic                 sel;
  logic                 below_lim;

  always_comb begin
    xs    = x_r >>> step_r;
    ys    = y_r >>> step_r;
    at    = $signed({{(ZW-32){1'b0}}, atan_val(step_r)});
    sel   = vec_r ? (y_r > 0) : (z_r < 0);
    ax    = x_r[XW-1] ? -x_r : x_r;
    ay    = y_r[XW-1] ? -y_r : y_r;
    below_lim = (ax < NORM_LIM) && (ay < NORM_LIM);
    if (sel) begin
      x_nxt = x_r + ys;
      y_nxt = y_r - xs;
      z_nxt = z_r + at;
    end else begin
      x_nxt = x_r - ys;
      y_nxt = y_r + xs;
      z_nxt = z_r - at;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= C_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      case (state_r)
        C_IDLE: begin
          if (req.start) begin
            vec_r  <= req.vec;
            step_r <= '0;
            // vectoring folds the left half plane over first
            if (req.vec && x_in < 0) begin
              x_r <= -x_in;
              y_r <= -y_in;
              z_r <= Z_PI;
            end else begin
              x_r <= x_in;
              y_r <= y_in;
              z_r <= z_in;
            end
            state_r <= req.vec ? C_NORM : C_ITER;
          end
        end
        C_NORM: begin
          if (below_lim) begin
            x_r <= x_r <<< 1;
            y_r <= y_r <<< 1;
          end else begin
            state_r <= C_ITER;
          end
        end
        C_ITER: begin
          x_r    <= x_nxt;
          y_r    <= y_nxt;
          z_r    <= z_nxt;
          step_r <= step_r + 1'b1;
          if (step_r == STEP_W'(CORDIC_STEPS - 1)) begin
            done_r  <= 1'b1;
            state_r <= C_IDLE;
          end
        end
        default: state_r <= C_IDLE;
      endcase
    end
  end

  assign done  = done_r;
  assign x_out = x_r;
  assign y_out = y_r;
  assign z_out = z_r;

endmodule
`default_nettype wire

/* hw/rtl/nearest_segment_pose_snap_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nearest_segment_pose_snap_core
// Snaps a query pose onto the stored 3-D centerline segment nearest in x and y.
// ----------------------------------------------------------------------------
// Input stream: tuser carries the command (clear, load, query), tdata the
// segment end points and the pose. A load into a full table is dropped. A
// query walks every stored segment with one shared multiplier (up to 8
// products a segment) and a 16-step restoring divider for the projection
// parameter, which is skipped when the parameter clamps. The winner then
// gets its height product and two cordic passes (vectoring, with
// pre-normalization and 30 steps, unless the segment lies along the x
// axis; rotation, 30 steps). A query with an empty table answers with
// found clear. in_tready is high only while the sequencer is idle.
// The result sits in an output register; if the receiver stalls, the
// block still takes clear and load words, and a following query waits
// at its end until the register frees. Reset empties the table and
// loads the register defaults; the segment memory itself is not cleared.
// Configuration writes take effect at once.
// ----------------------------------------------------------------------------
module nearest_segment_pose_snap_core
  import nsps_pkg::*;
#(
  parameter int MAX_SEGMENTS = 1024
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // start_x, start_y, start_z, end_x, end_y, end_z, pose_x, pose_y, pose_z
  input  wire logic [287:0] in_tdata,
  // cmd
  input  wire logic [1:0]   in_tuser,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // snap_x, snap_y, snap_z, heading, quat_z, quat_w
  output logic [143:0]      out_tdata,
  // found
  output logic [0:0]        out_tuser,
  input  wire logic         cfg_wr_en,
  input  wire logic [2:0]   cfg_addr,
  input  wire logic [31:0]  cfg_wr_data
);

  localparam int AW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int CW = $clog2(MAX_SEGMENTS + 1);
  localparam int EW = 6 * COORD_BITS;

  typedef enum logic [4:0] {
    S_IDLE, S_R2, S_RD, S_VEC, S_M_DOT1, S_M_DOT2, S_M_L1, S_M_L2,
    S_DIVPRE, S_DIV, S_M_TX, S_M_TY, S_DXY, S_M_DX, S_M_DY, S_CMP,
    S_NEXT, S_FIN, S_M_Z, S_ANG, S_ANG_W, S_ROT, S_ROT_W, S_OUT
  } state_t;

  // ---------------------------------------------------------------- helpers
  function automatic logic signed [31:0] sext_c(input logic [31:0] v);
    logic signed [COORD_BITS-1:0] c;
    c = v[COORD_BITS-1:0];
    return 32'(c);
  endfunction

  // floor((p + 2^15) / 2^16), value known to fit 35 bits
  function automatic logic signed [34:0] rnd16(input logic signed [PW-1:0] p);
    logic signed [PW-1:0] s;
    s = p + PW'(32768);
    return s[50:16];
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
    logic signed [31:0] r;
    if (v > 36'sd2147483647) r = 32'sh7fffffff;
    else if (v < -36'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

  function automatic logic signed [15:0] unit_rnd(input logic signed [XW-1:0] v);
    logic signed [XW-1:0] s;
    logic signed [XW-17:0] q;
    logic signed [15:0] r;
    s = v + XW'(32768);
    q = s[XW-1:16];
    if (q > (XW-16)'(16384)) r = 16'sd16384;
    else if (q < -(XW-16)'(16384)) r = -16'sd16384;
    else r = q[15:0];
    return r;
  endfunction

  // ---------------------------------------------------------------- config
  logic [30:0]        radius_r;
  logic               use_map_r;
  logic signed [31:0] offset_r;
  logic               flatten_r;
  logic signed [31:0] ground_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r  <= 31'd7680;
      use_map_r <= 1'b1;
      offset_r  <= '0;
      flatten_r <= 1'b0;
      ground_r  <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        REG_RADIUS:  radius_r  <= cfg_wr_data[30:0];
        REG_USE_MAP: use_map_r <= cfg_wr_data[0];
        REG_OFFSET:  offset_r  <= cfg_wr_data;
        REG_FLATTEN: flatten_r <= cfg_wr_data[0];
        REG_GROUND:  ground_r  <= cfg_wr_data;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- state
  state_t             state_r;
  logic [CW-1:0]      count_r;
  logic [CW-1:0]      idx_r;
  logic               mwait_r;
  logic signed [31:0] px_r, py_r, pz_r;
  logic [61:0]        r2_r;
  logic signed [31:0] sx_r, sy_r, sz_r, ez_r;
  logic signed [32:0] vx_r, vy_r, wx_r, wy_r;
  logic signed [PW-1:0] dot_r, len_r;
  logic [PW-1:0]      rem_r;
  logic [16:0]        t_r;
  logic [3:0]         dcnt_r;
  logic signed [34:0] prx_r, pry_r;
  logic signed [34:0] dx_r, dy_r;
  logic [63:0]        d_r;
  logic               found_r;
  logic [63:0]        best_r;
  logic [31:0]        bx_r, by_r;
  logic [16:0]        bt_r;
  logic signed [32:0] bvx_r, bvy_r;
  logic signed [31:0] bsz_r, bez_r;
  logic signed [16:0] bh_r;
  logic               res_found_r;
  logic [31:0]        res_x_r, res_y_r, res_z_r;
  logic [15:0]        res_h_r, res_qz_r, res_qw_r;
  logic               out_tvalid_r;
  logic [143:0]       out_tdata_r;
  logic               out_found_r;

  // ---------------------------------------------------------------- memory
  logic [EW-1:0] mem [MAX_SEGMENTS];
  logic [EW-1:0] rd_data_r;
  logic          wr_en;
  logic [EW-1:0] wr_entry;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[count_r[AW-1:0]] <= wr_entry;
    end
    rd_data_r <= mem[idx_r[AW-1:0]];
  end

  logic signed [31:0] rsx, rsy, rsz, rex, rey, rez;
  logic               in_acc;

  always_comb begin
    in_acc   = in_tvalid && (state_r == S_IDLE);
    wr_en    = in_acc && (in_tuser == CMD_LOAD) && (count_r < CW'(MAX_SEGMENTS));
    wr_entry = {in_tdata[160 +: COORD_BITS], in_tdata[128 +: COORD_BITS],
                in_tdata[96 +: COORD_BITS],  in_tdata[64 +: COORD_BITS],
                in_tdata[32 +: COORD_BITS],  in_tdata[0 +: COORD_BITS]};
    rsx = sext_c(32'(rd_data_r[0*COORD_BITS +: COORD_BITS]));
    rsy = sext_c(32'(rd_data_r[1*COORD_BITS +: COORD_BITS]));
    rsz = sext_c(32'(rd_data_r[2*COORD_BITS +: COORD_BITS]));
    rex = sext_c(32'(rd_data_r[3*COORD_BITS +: COORD_BITS]));
    rey = sext_c(32'(rd_data_r[4*COORD_BITS +: COORD_BITS]));
    rez = sext_c(32'(rd_data_r[5*COORD_BITS +: COORD_BITS]));
  end

  // ---------------------------------------------------------------- units
  logic                 mul_go, mul_done, is_mul;
  logic signed [MW-1:0] mul_a, mul_b;
  logic signed [PW-1:0] mul_p;
  cordic_req_t          cor_req;
  logic signed [XW-1:0] cor_x, cor_y, cor_xo, cor_yo;
  logic signed [ZW-1:0] cor_z, cor_zo;
  logic                 cor_done;

  always_comb begin
    is_mul = 1'b1;
    mul_a  = '0;
    mul_b  = '0;
    case (state_r)
      S_R2:     begin mul_a = MW'({1'b0, radius_r}); mul_b = MW'({1'b0, radius_r}); end
      S_M_DOT1: begin mul_a = MW'(vx_r); mul_b = MW'(wx_r); end
      S_M_DOT2: begin mul_a = MW'(vy_r); mul_b = MW'(wy_r); end
      S_M_L1:   begin mul_a = MW'(vx_r); mul_b = MW'(vx_r); end
      S_M_L2:   begin mul_a = MW'(vy_r); mul_b = MW'(vy_r); end
      S_M_TX:   begin mul_a = MW'({1'b0, t_r}); mul_b = MW'(vx_r); end
      S_M_TY:   begin mul_a = MW'({1'b0, t_r}); mul_b = MW'(vy_r); end
      S_M_DX:   begin mul_a = dx_r; mul_b = dx_r; end
      S_M_DY:   begin mul_a = dy_r; mul_b = dy_r; end
      S_M_Z:    begin mul_a = MW'({1'b0, bt_r}); mul_b = MW'(bez_r) - MW'(bsz_r); end
      default:  is_mul = 1'b0;
    endcase
    mul_go = is_mul && !mwait_r;

    cor_req.start = ((state_r == S_ANG) && (bvy_r != 0)) || (state_r == S_ROT);
    cor_req.vec   = (state_r == S_ANG);
    if (state_r == S_ANG) begin
      cor_x = XW'(bvx_r);
      cor_y = XW'(bvy_r);
      cor_z = '0;
    end else begin
      cor_x = 44'sd652032874;
      cor_y = '0;
      cor_z = ZW'(bh_r) <<< 15;
    end
  end

  nsps_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_go),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .p     (mul_p)
  );

  nsps_cordic u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (cor_req),
    .x_in  (cor_x),
    .y_in  (cor_y),
    .z_in  (cor_z),
    .done  (cor_done),
    .x_out (cor_xo),
    .y_out (cor_yo),
    .z_out (cor_zo)
  );

  // ---------------------------------------------------------------- datapath comb
  logic signed [35:0] dxc, dyc, adx, ady;
  logic [PW-1:0]      rem_sh;
  logic [PW-1:0]      len_u;
  logic signed [34:0] bz;
  logic signed [31:0] zsel;
  logic signed [31:0] zs32;
  logic signed [32:0] hsum;

  always_comb begin
    dxc    = 36'(px_r) - 36'(prx_r);
    dyc    = 36'(py_r) - 36'(pry_r);
    adx    = dxc[35] ? -dxc : dxc;
    ady    = dyc[35] ? -dyc : dyc;
    rem_sh = {rem_r[PW-2:0], 1'b0};
    len_u  = len_r;
    bz     = 35'(bsz_r) + rnd16(mul_p);
    if (flatten_r) zsel = sat32(36'(ground_r) + 36'(offset_r));
    else if (use_map_r) zsel = sat32(36'(bz) + 36'(offset_r));
    else zsel = pz_r;
    zs32   = cor_zo[31:0];
    hsum   = 33'(zs32) + 33'sd32768;
  end

  // ---------------------------------------------------------------- sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      count_r      <= '0;
      idx_r        <= '0;
      mwait_r      <= 1'b0;
      found_r      <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      if (out_tvalid_r && out_tready && state_r != S_OUT) begin
        out_tvalid_r <= 1'b0;
      end
      if (is_mul && !mul_done) begin
        mwait_r <= 1'b1;
      end
      if (mul_done) begin
        mwait_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            case (in_tuser)
              CMD_CLEAR: count_r <= '0;
              CMD_LOAD: begin
                if (wr_en) count_r <= count_r + 1'b1;
              end
              CMD_QUERY: begin
                px_r    <= sext_c(in_tdata[223:192]);
                py_r    <= sext_c(in_tdata[255:224]);
                pz_r    <= sext_c(in_tdata[287:256]);
                state_r <= S_R2;
              end
              default: ;
            endcase
          end
        end
        S_R2: begin
          if (mul_done) begin
            r2_r    <= mul_p[61:0];
            idx_r   <= '0;
            found_r <= 1'b0;
            state_r <= (count_r == '0) ? S_FIN : S_RD;
          end
        end
        S_RD: state_r <= S_VEC;
        S_VEC: begin
          sx_r    <= rsx;
          sy_r    <= rsy;
          sz_r    <= rsz;
          ez_r    <= rez;
          vx_r    <= 33'(rex) - 33'(rsx);
          vy_r    <= 33'(rey) - 33'(rsy);
          wx_r    <= 33'(px_r) - 33'(rsx);
          wy_r    <= 33'(py_r) - 33'(rsy);
          state_r <= S_M_DOT1;
        end
        S_M_DOT1: if (mul_done) begin dot_r <= mul_p; state_r <= S_M_DOT2; end
        S_M_DOT2: if (mul_done) begin dot_r <= dot_r + mul_p; state_r <= S_M_L1; end
        S_M_L1:   if (mul_done) begin len_r <= mul_p; state_r <= S_M_L2; end
        S_M_L2:   if (mul_done) begin len_r <= len_r + mul_p; state_r <= S_DIVPRE; end
        S_DIVPRE: begin
          t_r    <= '0;
          dcnt_r <= '0;
          rem_r  <= dot_r;
          // degenerate segment or pose behind the start clamps to zero
          if (len_r == 0 || dot_r <= 0) begin
            state_r <= S_M_TX;
          end else if (dot_r >= len_r) begin
            t_r     <= 17'd65536;
            state_r <= S_M_TX;
          end else begin
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          if (rem_sh >= len_u) begin
            rem_r <= rem_sh - len_u;
            t_r   <= {t_r[15:0], 1'b1};
          end else begin
            rem_r <= rem_sh;
            t_r   <= {t_r[15:0], 1'b0};
          end
          dcnt_r <= dcnt_r + 4'd1;
          if (dcnt_r == 4'd15) state_r <= S_M_TX;
        end
        S_M_TX: begin
          if (mul_done) begin
            prx_r   <= 35'(sx_r) + rnd16(mul_p);
            state_r <= S_M_TY;
          end
        end
        S_M_TY: begin
          if (mul_done) begin
            pry_r   <= 35'(sy_r) + rnd16(mul_p);
            state_r <= S_DXY;
          end
        end
        S_DXY: begin
          dx_r <= dxc[34:0];
          dy_r <= dyc[34:0];
          // too far to ever be within the radius
          if (adx >= 36'sd2147483648 || ady >= 36'sd2147483648) state_r <= S_NEXT;
          else state_r <= S_M_DX;
        end
        S_M_DX: if (mul_done) begin d_r <= mul_p[63:0]; state_r <= S_M_DY; end
        S_M_DY: if (mul_done) begin d_r <= d_r + mul_p[63:0]; state_r <= S_CMP; end
        S_CMP: begin
          if (d_r < {2'b00, r2_r} && (!found_r || d_r < best_r)) begin
            found_r <= 1'b1;
            best_r  <= d_r;
            bx_r    <= prx_r[31:0];
            by_r    <= pry_r[31:0];
            bt_r    <= t_r;
            bvx_r   <= vx_r;
            bvy_r   <= vy_r;
            bsz_r   <= sz_r;
            bez_r   <= ez_r;
          end
          state_r <= S_NEXT;
        end
        S_NEXT: begin
          idx_r   <= idx_r + 1'b1;
          state_r <= (idx_r + 1'b1 == count_r) ? S_FIN : S_RD;
        end
        S_FIN: begin
          res_found_r <= found_r;
          res_x_r     <= found_r ? bx_r : '0;
          res_y_r     <= found_r ? by_r : '0;
          res_z_r     <= '0;
          res_h_r     <= '0;
          res_qz_r    <= '0;
          res_qw_r    <= '0;
          state_r     <= found_r ? S_M_Z : S_OUT;
        end
        S_M_Z: begin
          if (mul_done) begin
            res_z_r <= zsel;
            state_r <= S_ANG;
          end
        end
        S_ANG: begin
          // segment along the x axis: heading exactly 0 or pi
          if (bvy_r == 0) begin
            bh_r    <= (bvx_r < 0) ? 17'sd32768 : 17'sd0;
            state_r <= S_ROT;
          end else begin
            state_r <= S_ANG_W;
          end
        end
        S_ANG_W: begin
          if (cor_done) begin
            bh_r    <= hsum[32:16];
            state_r <= S_ROT;
          end
        end
        S_ROT: begin
          res_h_r <= bh_r[15:0];
          state_r <= S_ROT_W;
        end
        S_ROT_W: begin
          if (cor_done) begin
            res_qz_r <= unit_rnd(cor_yo);
            res_qw_r <= unit_rnd(cor_xo);
            state_r  <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_tvalid_r || out_tready) begin
            out_tvalid_r <= 1'b1;
            out_found_r  <= res_found_r;
            out_tdata_r  <= {res_qw_r, res_qz_r, res_h_r, res_z_r, res_y_r, res_x_r};
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_found_r;

endmodule
`default_nettype wire
